// ----- rtl/fsa_pkg.sv -----
// Shared types, codes and helpers for the fragmented sparse array.
// Used by fsa_div and fragmented_sparse_array; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fsa_pkg;
    localparam int MAX_FRAGMENTS      = 64;
    localparam int MAX_FRAGMENT_CELLS = 64;
    localparam int FRAG_BITS  = $clog2(MAX_FRAGMENTS);
    localparam int CELL_BITS  = $clog2(MAX_FRAGMENT_CELLS);
    localparam int ADDR_BITS  = FRAG_BITS + CELL_BITS;
    localparam int STORE_CELLS = MAX_FRAGMENTS * MAX_FRAGMENT_CELLS;
    localparam int CFG_W      = 7;
    localparam int IDX_BITS   = 15;
    localparam int DIV_CNT_W  = 4;
    localparam int DATA_W     = 32;
    localparam int FILL_W     = 7;
    localparam int USED_W     = 13;
    localparam int ACT_W      = 7;

    typedef enum logic [2:0] {
        ACT_SET      = 3'd0,
        ACT_GET      = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_CONTAINS = 3'd3,
        ACT_ISSET    = 3'd4,
        ACT_CLEAR    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_UNSET = 2'd2
    } t_status;

    typedef enum logic {
        CFG_FRAG_COUNT = 1'b0,
        CFG_FRAG_SIZE  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RANGE, ST_DIV, ST_READ, ST_EXEC, ST_SRD, ST_SCMP
    } t_state;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] index;
        logic signed [31:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  value;
        logic                hit;
        logic                fragment_opened;
        logic                fragment_closed;
        logic [USED_W-1:0]   used_cells;
        logic [ACT_W-1:0]    active_fragments;
    } t_res;

    // Saturate a register write to 1..hi
    function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) r = CFG_W'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/fragmented_sparse_array.sv -----
// Top level of the fragmented sparse array: sequencer, cell store and counters.
// Depends on fsa_pkg, fsa_ram and fsa_div.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Request channel: drive i_req and raise start; the beat is taken at an edge
//   where start is high and busy is low. busy stays high until the result.
//   Result channel: o_done is high for exactly one cycle with o_res; the
//   receiver cannot stall it, so capture it in that cycle.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
//   (0 fragment count, 1 fragment size, both saturated to 1..64); write only
//   while idle.
// Sequence
//   Set, get, delete and is-set: a range check, the divider (15 quotient
//   bits in turn), a read state and an execute state, then the result. Out
//   of range: the result follows the range check. Undefined actions: the
//   result is strobed in the cycle after the accept and busy never rises.
//   Contains: a read and a compare state per cell visited through the single
//   RAM read port, stopping at the first match or after the last cell.
//   Clear-all: a sweep over all 4096 cells of the store, then the result.
// Reset
//   The same sweep clears the valid bits and fill counts after reset; busy
//   is high during it and no result is given for it.
module fragmented_sparse_array import fsa_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output logic                  o_done,
    output t_res                  o_res,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    t_state               r_state, n_state;
    t_req                 r_req;
    logic [CFG_W-1:0]     r_fcount, r_fsize;
    logic [ADDR_BITS-1:0] r_clr, n_clr;
    logic                 r_clr_res, n_clr_res;
    logic [FRAG_BITS-1:0] r_sf, n_sf;
    logic [CELL_BITS-1:0] r_so, n_so;
    logic [USED_W-1:0]    r_used, n_used;
    logic [ACT_W-1:0]     r_active, n_active;
    logic                 r_done, n_done;
    t_res                 r_res, n_res;

    logic                     in_range, div_start, div_done;
    logic [2*CFG_W-1:0]       limit;
    logic [IDX_BITS-1:0]      quot;
    logic [CFG_W-1:0]         rem;
    logic [ADDR_BITS-1:0]     cell_addr, d_raddr, d_waddr;
    logic                     d_we, f_we;
    logic [DATA_W:0]          d_wdata, d_q;
    logic [FRAG_BITS-1:0]     f_waddr;
    logic [FILL_W-1:0]        f_wdata, f_q;
    logic                     srch_last_o, srch_last_f, srch_hit;

    // Range check: non-negative and below count * size
    assign limit    = r_fcount * r_fsize;
    assign in_range = !r_req.index[15] &&
                      ({1'b0, r_req.index[IDX_BITS-1:0]} < {2'b00, limit});
    assign cell_addr = {quot[FRAG_BITS-1:0], rem[CELL_BITS-1:0]};

    fsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_req.index[IDX_BITS-1:0]),
        .i_divisor  (r_fsize),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // Cell store: valid bit on top of the 32-bit value
    fsa_ram #(.WIDTH(DATA_W + 1), .DEPTH(STORE_CELLS)) u_cells (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_q)
    );

    // Fill count per fragment
    fsa_ram #(.WIDTH(FILL_W), .DEPTH(MAX_FRAGMENTS)) u_fill (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (quot[FRAG_BITS-1:0]),
        .o_rdata (f_q)
    );

    assign srch_hit    = d_q[DATA_W] && (d_q[DATA_W-1:0] == r_req.key);
    assign srch_last_o = ({1'b0, r_so} == r_fsize - 1'b1);
    assign srch_last_f = ({1'b0, r_sf} == r_fcount - 1'b1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    case (i_req.action)
                        ACT_SET, ACT_GET, ACT_DELETE, ACT_ISSET: n_state = ST_RANGE;
                        ACT_CONTAINS: n_state = ST_SRD;
                        ACT_CLEAR:    n_state = ST_CLEAR;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RANGE: n_state = in_range ? ST_DIV : ST_IDLE;
            ST_DIV:   if (div_done) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            ST_SRD:   n_state = ST_SCMP;
            ST_SCMP:  n_state = (srch_hit || (srch_last_o && srch_last_f)) ? ST_IDLE : ST_SRD;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath, store access and result
    always_comb begin
        n_clr     = r_clr;
        n_clr_res = r_clr_res;
        n_sf      = r_sf;
        n_so      = r_so;
        n_used    = r_used;
        n_active  = r_active;
        n_done    = 1'b0;
        n_res     = '0;
        div_start = 1'b0;
        d_we      = 1'b0;
        d_waddr   = cell_addr;
        d_wdata   = {1'b0, d_q[DATA_W-1:0]};
        d_raddr   = cell_addr;
        f_we      = 1'b0;
        f_waddr   = quot[FRAG_BITS-1:0];
        f_wdata   = f_q;
        case (r_state)
            ST_CLEAR: begin
                // wipe one cell and one fill count a cycle
                d_we    = 1'b1;
                d_waddr = r_clr;
                d_wdata = '0;
                f_we    = 1'b1;
                f_waddr = r_clr[FRAG_BITS-1:0];
                f_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_done    = r_clr_res;
                    n_clr_res = 1'b0;
                end
            end
            ST_IDLE: begin
                n_sf = '0;
                n_so = '0;
                if (start) begin
                    case (i_req.action)
                        ACT_CLEAR: begin
                            n_clr     = '0;
                            n_clr_res = 1'b1;
                            n_used    = '0;
                            n_active  = '0;
                        end
                        ACT_SET, ACT_GET, ACT_DELETE, ACT_ISSET, ACT_CONTAINS: ;
                        default: n_done = 1'b1;
                    endcase
                end
            end
            ST_RANGE: begin
                div_start = in_range;
                if (!in_range) begin
                    n_done       = 1'b1;
                    n_res.status = STAT_RANGE;
                end
            end
            ST_EXEC: begin
                n_done = 1'b1;
                case (r_req.action)
                    ACT_SET: begin
                        if (f_q == '0) begin
                            n_res.fragment_opened = 1'b1;
                            n_active = r_active + 1'b1;
                        end
                        d_we    = 1'b1;
                        d_wdata = {1'b1, r_req.key};
                        if (!d_q[DATA_W]) begin
                            f_we    = 1'b1;
                            f_wdata = f_q + 1'b1;
                            n_used  = r_used + 1'b1;
                        end
                    end
                    ACT_GET: begin
                        if (d_q[DATA_W]) n_res.value  = d_q[DATA_W-1:0];
                        else             n_res.status = STAT_UNSET;
                    end
                    ACT_DELETE: begin
                        if (!d_q[DATA_W]) begin
                            n_res.status = STAT_UNSET;
                        end else begin
                            d_we    = 1'b1;
                            f_we    = 1'b1;
                            f_wdata = f_q - 1'b1;
                            n_used  = r_used - 1'b1;
                            if (f_q == FILL_W'(1)) begin
                                n_res.fragment_closed = 1'b1;
                                n_active = r_active - 1'b1;
                            end
                        end
                    end
                    default: n_res.hit = d_q[DATA_W];
                endcase
            end
            ST_SRD: d_raddr = {r_sf, r_so};
            ST_SCMP: begin
                // advance offset, then fragment, until a match or the end
                if (srch_hit || (srch_last_o && srch_last_f)) begin
                    n_done    = 1'b1;
                    n_res.hit = srch_hit;
                end else if (srch_last_o) begin
                    n_so = '0;
                    n_sf = r_sf + 1'b1;
                end else begin
                    n_so = r_so + 1'b1;
                end
            end
            default: ;
        endcase
        n_res.used_cells       = n_used;
        n_res.active_fragments = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_clr_res <= 1'b0;
            r_used    <= '0;
            r_active  <= '0;
            r_done    <= 1'b0;
            r_fcount  <= CFG_W'(MAX_FRAGMENTS);
            r_fsize   <= CFG_W'(MAX_FRAGMENT_CELLS);
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_res <= n_clr_res;
            r_used    <= n_used;
            r_active  <= n_active;
            r_done    <= n_done;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAG_COUNT: r_fcount <= clamp_reg(i_cfg_data, CFG_W'(MAX_FRAGMENTS));
                    CFG_FRAG_SIZE:  r_fsize  <= clamp_reg(i_cfg_data,
                                                          CFG_W'(MAX_FRAGMENT_CELLS));
                    default: ;
                endcase
            end
        end
        if (r_state == ST_IDLE && start) r_req <= i_req;
        r_sf  <= n_sf;
        r_so  <= n_so;
        r_res <= n_res;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    // A result leaves only as the block returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");
    // An accepted request with a defined action keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.action <= ACT_CLEAR)) |=> busy)
        else $error("request not taken");
    // Opening a fragment only happens on a successful set
    a_open_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.fragment_opened) |-> (o_res.status == STAT_OK))
        else $error("fragment opened on failed request");
    // The cell count never exceeds the store
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.used_cells <= USED_W'(STORE_CELLS)))
        else $error("used cell count overflow");
endmodule
`default_nettype wire

// ----- rtl/fsa_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/fsa_div.sv -----
// Restoring divider, one quotient bit a cycle: splits an index into
// fragment and offset. Depends on fsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fsa_div import fsa_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [IDX_BITS-1:0] i_dividend,
    input  wire logic [CFG_W-1:0]    i_divisor,
    output logic                     o_done,
    output logic [IDX_BITS-1:0]      o_quot,
    output logic [CFG_W-1:0]         o_rem
);
    logic                 r_run, n_run, r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_BITS-1:0]  r_q, n_q;
    logic [CFG_W-1:0]     r_rem, n_rem, shifted;

    always_comb begin
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        shifted = {r_rem[CFG_W-2:0], r_q[IDX_BITS-1]};
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = DIV_CNT_W'(IDX_BITS);
            n_q   = i_dividend;
            n_rem = '0;
        end else if (r_run) begin
            // shift in the next dividend bit, subtract where it fits
            if (shifted >= i_divisor) begin
                n_rem = shifted - i_divisor;
                n_q   = {r_q[IDX_BITS-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {r_q[IDX_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ----- verif/tb_fragmented_sparse_array.sv -----
// Self-checking testbench for the fragmented sparse array: directed and random
// request beats, checked against an in-bench model of the store and counters.
// Depends on fsa_pkg and the fragmented_sparse_array RTL.
`timescale 1ns / 1ps
`default_nettype none

// Holds a model of the array and the queue of results still owed by the block.
class fsa_scoreboard;
    logic [6:0]  frag_count;
    logic [6:0]  frag_size;
    logic [31:0] cell_word [4096];
    bit          cell_set  [4096];
    int unsigned frag_fill [64];
    logic [12:0] used_cells;
    logic [6:0]  live_frags;
    fsa_pkg::t_res pending [$];
    int errors;

    function new();
        frag_count = 7'd64;
        frag_size = 7'd64;
        for (int i = 0; i < 4096; i++) cell_set[i] = 0;
        for (int i = 0; i < 64; i++) frag_fill[i] = 0;
        used_cells = '0;
        live_frags = '0;
        errors = 0;
    endfunction

    function void write_reg(fsa_pkg::t_cfg_idx idx, logic [6:0] data);
        logic [6:0] v;
        v = (data == 0) ? 7'd1 : (data > 7'd64 ? 7'd64 : data);
        if (idx == fsa_pkg::CFG_FRAG_COUNT) frag_count = v;
        else frag_size = v;
    endfunction

    // Work out the result of one accepted request beat and queue it.
    function void note_request(fsa_pkg::t_req rq);
        fsa_pkg::t_res r;
        logic [15:0] raw;
        bit in_rng;
        int unsigned frag, addr, a;
        r = '0;
        raw = rq.index;
        in_rng = 0;
        frag = 0;
        addr = 0;
        if (!raw[15] && int'(raw) < int'(frag_count) * int'(frag_size)) begin
            in_rng = 1;
            frag = raw / frag_size;
            addr = frag * 64 + raw % frag_size;
        end
        case (rq.action)
            fsa_pkg::ACT_SET, fsa_pkg::ACT_GET, fsa_pkg::ACT_DELETE, fsa_pkg::ACT_ISSET: begin
                if (!in_rng) begin
                    r.status = fsa_pkg::STAT_RANGE;
                end else if (rq.action == fsa_pkg::ACT_SET) begin
                    if (frag_fill[frag] == 0) begin
                        r.fragment_opened = 1;
                        live_frags++;
                    end
                    if (!cell_set[addr]) begin
                        cell_set[addr] = 1;
                        frag_fill[frag]++;
                        used_cells++;
                    end
                    cell_word[addr] = rq.key;
                end else if (rq.action == fsa_pkg::ACT_GET) begin
                    if (cell_set[addr]) r.value = cell_word[addr];
                    else r.status = fsa_pkg::STAT_UNSET;
                end else if (rq.action == fsa_pkg::ACT_DELETE) begin
                    if (!cell_set[addr]) begin
                        r.status = fsa_pkg::STAT_UNSET;
                    end else begin
                        cell_set[addr] = 0;
                        frag_fill[frag]--;
                        used_cells--;
                        if (frag_fill[frag] == 0) begin
                            r.fragment_closed = 1;
                            live_frags--;
                        end
                    end
                end else begin
                    r.hit = cell_set[addr];
                end
            end
            fsa_pkg::ACT_CONTAINS: begin
                for (int f = 0; f < frag_count && !r.hit; f++)
                    for (int o = 0; o < frag_size; o++) begin
                        a = f * 64 + o;
                        if (cell_set[a] && cell_word[a] == rq.key) begin
                            r.hit = 1;
                            break;
                        end
                    end
            end
            fsa_pkg::ACT_CLEAR: begin
                for (int i = 0; i < 4096; i++) cell_set[i] = 0;
                for (int i = 0; i < 64; i++) frag_fill[i] = 0;
                used_cells = '0;
                live_frags = '0;
            end
            default: ;
        endcase
        r.used_cells = used_cells;
        r.active_fragments = live_frags;
        pending.push_back(r);
    endfunction

    function void check_result(fsa_pkg::t_res got);
        fsa_pkg::t_res exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result exp none act %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
            $display("%0t: status exp %0d act %0d", $time, exp.status, got.status);
            errors++;
        end
        if (got.value !== exp.value) begin
            $display("%0t: value exp %h act %h", $time, exp.value, got.value);
            errors++;
        end
        if (got.hit !== exp.hit) begin
            $display("%0t: hit exp %b act %b", $time, exp.hit, got.hit);
            errors++;
        end
        if (got.fragment_opened !== exp.fragment_opened) begin
            $display("%0t: opened exp %b act %b", $time, exp.fragment_opened,
                     got.fragment_opened);
            errors++;
        end
        if (got.fragment_closed !== exp.fragment_closed) begin
            $display("%0t: closed exp %b act %b", $time, exp.fragment_closed,
                     got.fragment_closed);
            errors++;
        end
        if (got.used_cells !== exp.used_cells) begin
            $display("%0t: used exp %0d act %0d", $time, exp.used_cells, got.used_cells);
            errors++;
        end
        if (got.active_fragments !== exp.active_fragments) begin
            $display("%0t: active exp %0d act %0d", $time, exp.active_fragments,
                     got.active_fragments);
            errors++;
        end
    endfunction
endclass

module tb_fragmented_sparse_array;
    import fsa_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [6:0]  i_cfg_data = '0;

    fsa_scoreboard sb;
    int          cycles = 0;
    logic [31:0] recent_keys [8];

    fragmented_sparse_array u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Check every result beat in the cycle it is strobed; none can be held off.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) sb.check_result(o_res);
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one request beat and hold it until busy is seen low.
    task automatic send_request(t_action act, logic [15:0] idx, logic [31:0] key);
        t_req rq;
        rq.action = act;
        rq.index = idx;
        rq.key = key;
        i_req <= rq;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(rq);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain outstanding results, then allow for the slowest sweep to finish.
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [6:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Random index, mostly inside the current geometry, sometimes anywhere or just past its end.
    function automatic logic [15:0] pick_index();
        int cap;
        cap = int'(sb.frag_count) * int'(sb.frag_size);
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'(cap);
            default: return 16'($urandom_range(0, cap - 1));
        endcase
    endfunction

    // Random beat: sets and lookups dominate, with occasional sweeps and junk codes.
    task automatic random_request();
        int pick;
        logic [31:0] key;
        t_action act;
        pick = $urandom_range(0, 99);
        key = ($urandom_range(0, 1) == 1) ? recent_keys[$urandom_range(0, 7)] : $urandom;
        if (pick < 35) act = ACT_SET;
        else if (pick < 55) act = ACT_GET;
        else if (pick < 72) act = ACT_DELETE;
        else if (pick < 84) act = ACT_ISSET;
        else if (pick < 95) act = ACT_CONTAINS;
        else if (pick < 97) act = ACT_CLEAR;
        else act = t_action'(3'($urandom_range(6, 7)));
        if (act == ACT_SET) recent_keys[$urandom_range(0, 7)] = key;
        send_request(act, pick_index(), key);
    endtask

    // One phase of random traffic in bursts separated by random gaps.
    task automatic random_phase(int beats);
        int burst;
        while (beats > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && beats > 0) begin
                random_request();
                burst--;
                beats--;
            end
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
        end
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < 8; i++) recent_keys[i] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, each action and empty fragments.
        send_request(ACT_GET, 16'd0, 32'd0);
        send_request(ACT_DELETE, 16'd5, 32'd0);
        send_request(ACT_SET, 16'd0, 32'h8000_0000);
        send_request(ACT_SET, 16'd0, 32'h7fff_ffff);
        send_request(ACT_SET, 16'd4095, 32'hffff_ffff);
        send_request(ACT_SET, 16'd4096, 32'h1);
        send_request(ACT_SET, 16'h8000, 32'h1);
        send_request(ACT_GET, 16'hffff, 32'h0);
        send_request(ACT_ISSET, 16'h7fff, 32'h0);
        send_request(ACT_GET, 16'd0, 32'h0);
        send_request(ACT_ISSET, 16'd4095, 32'h0);
        send_request(ACT_ISSET, 16'd1, 32'h0);
        send_request(ACT_CONTAINS, 16'h5555, 32'hffff_ffff);
        send_request(ACT_CONTAINS, 16'haaaa, 32'h1234_5678);
        send_request(ACT_DELETE, 16'd4095, 32'h0);
        send_request(ACT_DELETE, 16'd4095, 32'h0);
        send_request(t_action'(3'd6), 16'd0, 32'h0);
        send_request(t_action'(3'd7), 16'd0, 32'h0);
        send_request(ACT_CLEAR, 16'd0, 32'h0);
        send_request(ACT_GET, 16'd0, 32'h0);
        wait_drained();

        // Small geometry, zero and over-range writes saturate.
        write_reg(CFG_FRAG_COUNT, 7'd0);
        write_reg(CFG_FRAG_SIZE, 7'd127);
        random_phase(60);
        wait_drained();
        write_reg(CFG_FRAG_COUNT, 7'd4);
        write_reg(CFG_FRAG_SIZE, 7'd3);
        random_phase(120);
        wait_drained();
        write_reg(CFG_FRAG_COUNT, 7'd64);
        write_reg(CFG_FRAG_SIZE, 7'd1);
        random_phase(100);
        wait_drained();
        write_reg(CFG_FRAG_COUNT, 7'd2);
        write_reg(CFG_FRAG_SIZE, 7'd64);
        random_phase(90);
        wait_drained();
        write_reg(CFG_FRAG_COUNT, 7'd64);
        write_reg(CFG_FRAG_SIZE, 7'd64);
        random_phase(80);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
